FILE: src/tufn_pkg.sv
package tufn_pkg;

    // Queue depths between the parts of the block
    localparam int unsigned MID_DEPTH = 4;
    localparam int unsigned OUT_DEPTH = 2;

endpackage

FILE: src/triangle_unit_face_normal.sv
// Triangle unit face normal.
// Input queue side: drive the nine vertex coordinates and raise push; a
// triangle transfers on a rising edge with push high and full low.
// Result queue side: while empty is low, unit_x/y/z and degenerate show the
// oldest result; it transfers on a rising edge with pop high.
// Normals are Q1.(NORMAL_BITS-2), rounded to nearest, ties away from zero.
// A zero cross product gives a zero vector with degenerate set.
// Throughput: one triangle per cycle while pop keeps up.
// From input transfer to empty falling a triangle passes two front stages
// for the cross product, a turn through the middle queue, square and sum
// stages, one stage per result bit of the restoring normaliser, a sign
// stage and the result queue.
// When pop is held low the result queue fills, the back pipeline stops,
// the middle queue absorbs the front, and full rises only once all are
// stalled; nothing is dropped.
// Reset empties both queues and clears all stage valids at once.
module triangle_unit_face_normal #(
    parameter int unsigned COORD_BITS  = 16,
    parameter int unsigned NORMAL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_BITS-1:0]  a_x,
    input  logic signed [COORD_BITS-1:0]  a_y,
    input  logic signed [COORD_BITS-1:0]  a_z,
    input  logic signed [COORD_BITS-1:0]  b_x,
    input  logic signed [COORD_BITS-1:0]  b_y,
    input  logic signed [COORD_BITS-1:0]  b_z,
    input  logic signed [COORD_BITS-1:0]  c_x,
    input  logic signed [COORD_BITS-1:0]  c_y,
    input  logic signed [COORD_BITS-1:0]  c_z,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [NORMAL_BITS-1:0] unit_x,
    output logic signed [NORMAL_BITS-1:0] unit_y,
    output logic signed [NORMAL_BITS-1:0] unit_z,
    output logic                          degenerate
);

    localparam int unsigned NW  = 2 * COORD_BITS + 2;
    localparam int unsigned MDW = 3 * NW + 1;
    localparam int unsigned ODW = 3 * NORMAL_BITS + 1;

    logic           fr_valid, mid_full, mid_empty, bk_ready;
    logic [3*NW-1:0] fr_n;
    logic           fr_dg;
    logic [MDW-1:0] mid_rdata;
    logic           bk_valid, out_full;
    logic [3*NORMAL_BITS-1:0] bk_unit;
    logic           bk_dg;
    logic [ODW-1:0] out_rdata;

    // Front: edges and cross product
    tufn_front #(.CW(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_z       (c_z),
        .out_valid (fr_valid),
        .out_ready (!mid_full),
        .out_n     (fr_n),
        .out_dg    (fr_dg)
    );

    // Decoupling queue
    tufn_fifo #(.WIDTH(MDW), .DEPTH(tufn_pkg::MID_DEPTH)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_valid),
        .wdata ({fr_n, fr_dg}),
        .full  (mid_full),
        .pop   (bk_ready),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    // Back: normalisation
    tufn_back #(.CW(COORD_BITS), .NB(NORMAL_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty),
        .in_ready  (bk_ready),
        .in_n      (mid_rdata[MDW-1:1]),
        .in_dg     (mid_rdata[0]),
        .out_valid (bk_valid),
        .out_ready (!out_full),
        .out_unit  (bk_unit),
        .out_dg    (bk_dg)
    );

    // Result queue
    tufn_fifo #(.WIDTH(ODW), .DEPTH(tufn_pkg::OUT_DEPTH)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_valid),
        .wdata ({bk_unit, bk_dg}),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign unit_x     = out_rdata[ODW-1:2*NORMAL_BITS+1];
    assign unit_y     = out_rdata[2*NORMAL_BITS:NORMAL_BITS+1];
    assign unit_z     = out_rdata[NORMAL_BITS:1];
    assign degenerate = out_rdata[0];

endmodule

FILE: src/tufn_fifo.sv
module tufn_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      rd_ptr_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0])
                     && (wr_ptr_reg[AW] != rd_ptr_reg[AW]);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg[AW-1:0]];

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wdata;
        end
    end

endmodule

FILE: src/tufn_front.sv
module tufn_front #(
    parameter int unsigned CW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic signed [CW-1:0]   a_x,
    input  logic signed [CW-1:0]   a_y,
    input  logic signed [CW-1:0]   a_z,
    input  logic signed [CW-1:0]   b_x,
    input  logic signed [CW-1:0]   b_y,
    input  logic signed [CW-1:0]   b_z,
    input  logic signed [CW-1:0]   c_x,
    input  logic signed [CW-1:0]   c_y,
    input  logic signed [CW-1:0]   c_z,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3*(2*CW+2)-1:0]  out_n,
    output logic                   out_dg
);

    localparam int unsigned EW = CW + 1;
    localparam int unsigned NW = 2 * EW;

    logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [NW-1:0] prod_next [0:5];
    logic signed [NW-1:0] prod_reg  [0:5];
    logic signed [NW-1:0] n_next    [0:2];
    logic signed [NW-1:0] n_reg     [0:2];
    logic                 dg_reg;
    logic                 v0_reg, v1_reg;
    logic                 en0, en1;

    // Edge vectors, sign extended by one bit
    assign e1x = {b_x[CW-1], b_x} - {a_x[CW-1], a_x};
    assign e1y = {b_y[CW-1], b_y} - {a_y[CW-1], a_y};
    assign e1z = {b_z[CW-1], b_z} - {a_z[CW-1], a_z};
    assign e2x = {c_x[CW-1], c_x} - {a_x[CW-1], a_x};
    assign e2y = {c_y[CW-1], c_y} - {a_y[CW-1], a_y};
    assign e2z = {c_z[CW-1], c_z} - {a_z[CW-1], a_z};

    // Cross product partial products
    assign prod_next[0] = e1y * e2z;
    assign prod_next[1] = e1z * e2y;
    assign prod_next[2] = e1z * e2x;
    assign prod_next[3] = e1x * e2z;
    assign prod_next[4] = e1x * e2y;
    assign prod_next[5] = e1y * e2x;

    assign n_next[0] = prod_reg[0] - prod_reg[1];
    assign n_next[1] = prod_reg[2] - prod_reg[3];
    assign n_next[2] = prod_reg[4] - prod_reg[5];

    // Elastic stage enables
    assign en1  = !v1_reg || out_ready;
    assign en0  = !v0_reg || en1;
    assign full = !en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= push;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            for (int i = 0; i < 6; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (en1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= n_next[i];
            end
            dg_reg <= (n_next[0] == '0) && (n_next[1] == '0) && (n_next[2] == '0);
        end
    end

    assign out_valid = v1_reg;
    assign out_n     = {n_reg[0], n_reg[1], n_reg[2]};
    assign out_dg    = dg_reg;

endmodule

FILE: src/tufn_back.sv
module tufn_back #(
    parameter int unsigned CW = 16,
    parameter int unsigned NB = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [3*(2*CW+2)-1:0]  in_n,
    input  logic                   in_dg,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3*NB-1:0]        out_unit,
    output logic                   out_dg
);

    localparam int unsigned F   = NB - 2;
    localparam int unsigned NW  = 2 * CW + 2;
    localparam int unsigned MW  = 2 * CW + 1;
    localparam int unsigned SQW = 2 * MW;
    localparam int unsigned SW  = SQW + 2;
    localparam int unsigned VW  = SW + 2 * F + 4;
    localparam int unsigned NST = F + 1;
    localparam int unsigned NS  = NST + 3;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // Square stage
    logic signed [NW-1:0] n_in  [0:2];
    logic [MW-1:0]        mag   [0:2];
    logic [SQW-1:0]       sq_reg  [0:2];
    logic                 neg0_reg [0:2];
    logic                 dg0_reg;

    // Bit stages: index 0 is the sum stage output
    logic [VW-1:0]  lhs_reg [0:NST][0:2];
    logic [VW-1:0]  a_reg   [0:NST][0:2];
    logic [VW-1:0]  b_reg   [0:NST][0:2];
    logic [F:0]     q_reg   [0:NST][0:2];
    logic [SW-1:0]  s_reg   [0:NST];
    logic           neg_reg [0:NST][0:2];
    logic           dg_reg  [0:NST];

    logic signed [NB-1:0] unit_reg [0:2];
    logic                 odg_reg;

    // Elastic enables, back to front
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign n_in[0] = in_n[3*NW-1:2*NW];
    assign n_in[1] = in_n[2*NW-1:NW];
    assign n_in[2] = in_n[NW-1:0];

    // Magnitudes; they fit MW bits
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            mag[j] = n_in[j][NW-1] ? MW'(-n_in[j]) : MW'(n_in[j]);
        end
    end

    // Squares
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < 3; j++)
            begin
                sq_reg[j]   <= mag[j] * mag[j];
                neg0_reg[j] <= n_in[j][NW-1];
            end
            dg0_reg <= in_dg;
        end
    end

    // Sum of squares and scaled left sides
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s_reg[0]  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            dg_reg[0] <= dg0_reg;
            for (int j = 0; j < 3; j++)
            begin
                lhs_reg[0][j] <= VW'(sq_reg[j]) << (2 * F + 2);
                a_reg[0][j]   <= '0;
                b_reg[0][j]   <= '0;
                q_reg[0][j]   <= '0;
                neg_reg[0][j] <= neg0_reg[j];
            end
        end
    end

    // One quotient bit per stage; A tracks T^2*S, B tracks T*S with T = 2q
    for (genvar s = 0; s < NST; s++)
    begin : g_bit
        localparam int unsigned BIT = F - s;
        for (genvar j = 0; j < 3; j++)
        begin : g_comp
            logic [VW-1:0] bn, an;
            logic          pass;

            always_comb
            begin
                bn   = b_reg[s][j] + (VW'(s_reg[s]) << (BIT + 1));
                an   = a_reg[s][j] + (b_reg[s][j] << (BIT + 2))
                       + (VW'(s_reg[s]) << (2 * BIT + 2));
                pass = !q_reg[s][j][F]
                       && ((lhs_reg[s][j] + (bn << 1)) >= (an + VW'(s_reg[s])));
            end

            always_ff @(posedge clk)
            begin
                if (en[s+2])
                begin
                    lhs_reg[s+1][j] <= lhs_reg[s][j];
                    neg_reg[s+1][j] <= neg_reg[s][j];
                    if (pass)
                    begin
                        q_reg[s+1][j] <= q_reg[s][j] | ((F+1)'(1) << BIT);
                        a_reg[s+1][j] <= an;
                        b_reg[s+1][j] <= bn;
                    end
                    else
                    begin
                        q_reg[s+1][j] <= q_reg[s][j];
                        a_reg[s+1][j] <= a_reg[s][j];
                        b_reg[s+1][j] <= b_reg[s][j];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s+2])
            begin
                s_reg[s+1]  <= s_reg[s];
                dg_reg[s+1] <= dg_reg[s];
            end
        end
    end

    // Sign and degenerate masking
    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (dg_reg[NST])
                begin
                    unit_reg[j] <= '0;
                end
                else if (neg_reg[NST][j])
                begin
                    unit_reg[j] <= -signed'(NB'(q_reg[NST][j]));
                end
                else
                begin
                    unit_reg[j] <= signed'(NB'(q_reg[NST][j]));
                end
            end
            odg_reg <= dg_reg[NST];
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_unit  = {unit_reg[0], unit_reg[1], unit_reg[2]};
    assign out_dg    = odg_reg;

endmodule

FILE: src/tufn_checker.sv
module tufn_props #(
    parameter int unsigned NORMAL_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic signed [NORMAL_BITS-1:0] unit_x,
    input logic signed [NORMAL_BITS-1:0] unit_y,
    input logic signed [NORMAL_BITS-1:0] unit_z,
    input logic                          degenerate
);

    localparam logic signed [NORMAL_BITS-1:0] ONE  = NORMAL_BITS'(1) << (NORMAL_BITS - 2);
    localparam logic signed [NORMAL_BITS-1:0] MONE = -ONE;

    // Reset leaves nothing to transfer
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty in reset");

    // Degenerate results carry a zero vector
    a_dg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && degenerate) |-> (unit_x == '0 && unit_y == '0 && unit_z == '0))
        else $error("degenerate result with non-zero normal");

    // Components stay within one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (unit_x <= ONE && unit_x >= MONE && unit_y <= ONE && unit_y >= MONE
                    && unit_z <= ONE && unit_z >= MONE))
        else $error("normal component out of range");

    // A waiting result stays until transferred; unit_x and degenerate are checked
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(unit_x) && $stable(degenerate)))
        else $error("waiting result lost or changed");

endmodule

bind triangle_unit_face_normal tufn_props #(.NORMAL_BITS(NORMAL_BITS)) u_tufn_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .unit_x     (unit_x),
    .unit_y     (unit_y),
    .unit_z     (unit_z),
    .degenerate (degenerate)
);
